// ----- rtl/aspect_fit_viewport_calculator_assert.svh -----
// Assertion macros shared by the viewport fit RTL
`ifndef ASPECT_FIT_VIEWPORT_CALCULATOR_ASSERT_SVH
`define ASPECT_FIT_VIEWPORT_CALCULATOR_ASSERT_SVH

// Check an implication outside reset
`define AFVC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its cause, reset included
`define AFVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/afvc_pkg.sv -----
`timescale 1ns / 1ps
package afvc_pkg;

  // Scaling modes
  typedef enum logic [1:0] {
    MODE_ASPECT = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_SQUARE = 2'd2,
    MODE_CUSTOM = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_RATIO  = 2'd1,
    REG_FILT   = 2'd2,
    REG_ROTATE = 2'd3
  } reg_idx_t;

  // Output systems
  localparam logic [1:0] SYS_LCD = 2'd0;
  localparam logic [1:0] SYS_PAL = 2'd1;

  // Screen sizes
  localparam logic [9:0] LCD_W  = 10'd320;
  localparam logic [9:0] LCD_H  = 10'd240;
  localparam logic [9:0] TV_W   = 10'd720;
  localparam logic [9:0] PAL_H  = 10'd576;
  localparam logic [9:0] NTSC_H = 10'd480;

  localparam logic [19:0] Q16_MAX     = 20'hFFFFF;
  localparam logic [19:0] RATIO_RESET = 20'd87381;
  localparam logic [9:0]  FIELD_MAX   = 10'd1023;

  // Per-word context that rides along the divider chains
  typedef struct packed {
    logic        swap;
    logic        menu;
    logic        kw;
    logic [9:0]  uw;
    logic [9:0]  uh;
    logic [9:0]  sw;
    logic [9:0]  sh;
    logic [9:0]  k;
    logic [19:0] ratio;
    logic [13:0] scw;
    logic [19:0] iw;
    logic [19:0] ih;
    logic [27:0] fw;
    logic [27:0] fh;
    logic        ml;
    logic        mt;
    logic [18:0] numt;
    logic [9:0]  dent;
    logic [9:0]  left;
  } ctx_t;

endpackage

// ----- rtl/afvc_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring division step: produces one quotient bit per cell
module afvc_div_cell #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             i_valid,
  input  logic [DEN_W-1:0] i_rem,
  input  logic [NUM_W-1:0] i_num,
  input  logic [NUM_W-1:0] i_quo,
  input  logic [DEN_W-1:0] i_den,
  input  logic [PAY_W-1:0] i_pay,
  output logic             o_valid,
  output logic [DEN_W-1:0] o_rem,
  output logic [NUM_W-1:0] o_num,
  output logic [NUM_W-1:0] o_quo,
  output logic [DEN_W-1:0] o_den,
  output logic [PAY_W-1:0] o_pay
);

  logic             valid_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [PAY_W-1:0] pay_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    trial   = {i_rem, i_num[NUM_W-1]};
    diff    = trial - {1'b0, i_den};
    ge      = trial >= {1'b0, i_den};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_nxt = {i_num[NUM_W-2:0], 1'b0};
    quo_nxt = {i_quo[NUM_W-2:0], ge};
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      den_r <= i_den;
      pay_r <= i_pay;
    end
  end

  assign o_valid = valid_r;
  assign o_rem   = rem_r;
  assign o_num   = num_r;
  assign o_quo   = quo_r;
  assign o_den   = den_r;
  assign o_pay   = pay_r;

endmodule

// ----- rtl/afvc_div.sv -----
`timescale 1ns / 1ps
`include "aspect_fit_viewport_calculator_assert.svh"
// Pipelined divider: a row of NUM_W cells, one quotient bit each
module afvc_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             i_valid,
  input  logic [NUM_W-1:0] i_num,
  input  logic [DEN_W-1:0] i_den,
  input  logic [PAY_W-1:0] i_pay,
  output logic             o_valid,
  output logic [NUM_W-1:0] o_quo,
  output logic [PAY_W-1:0] o_pay
);

  logic             v   [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0] num [0:NUM_W];
  logic [NUM_W-1:0] quo [0:NUM_W];
  logic [DEN_W-1:0] den [0:NUM_W];
  logic [PAY_W-1:0] pay [0:NUM_W];

  assign v[0]   = i_valid;
  assign rem[0] = '0;
  assign num[0] = i_num;
  assign quo[0] = '0;
  assign den[0] = i_den;
  assign pay[0] = i_pay;

  // Chain the cells
  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    afvc_div_cell #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W),
      .PAY_W(PAY_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .i_valid(v[g]),
      .i_rem  (rem[g]),
      .i_num  (num[g]),
      .i_quo  (quo[g]),
      .i_den  (den[g]),
      .i_pay  (pay[g]),
      .o_valid(v[g+1]),
      .o_rem  (rem[g+1]),
      .o_num  (num[g+1]),
      .o_quo  (quo[g+1]),
      .o_den  (den[g+1]),
      .o_pay  (pay[g+1])
    );
  end

  assign o_valid = v[NUM_W];
  assign o_quo   = quo[NUM_W];
  assign o_pay   = pay[NUM_W];

  `AFVC_ASSERT_IMPL(a_rem_below_den, o_valid && den[NUM_W] != '0, rem[NUM_W] < den[NUM_W],
    "division remainder not below divisor")
  `AFVC_ASSERT_IMPL(a_num_drained, o_valid, num[NUM_W] == '0,
    "numerator bits left after last cell")
  `AFVC_ASSERT_NEXT(a_hold_on_stall, rst_n && !en, $stable(o_quo),
    "quotient moved while stalled")

endmodule

// ----- rtl/aspect_fit_viewport_calculator.sv -----
`timescale 1ns / 1ps
`include "aspect_fit_viewport_calculator_assert.svh"
// Channel | Group                     | Contents
// in      | in_tvalid/tready/tdata    | source size; tuser = output system
// out     | out_tvalid/tready/tdata   | scaler size and source-pixel margins
// cfg     | cfg_we/addr/wdata         | mode, ratio, filtered, rotate
//
// One word enters per cycle unless out_tready stalls the pipe. Data passes
// five divider cell rows (10 + 28 + 28 + 19 + 19 cells) plus two context
// stages and the output register. A stall on out_tready freezes the whole
// row, and in_tready drops with it. Reset (rst_n low, synchronous) empties
// the pipe and loads the register defaults.
module aspect_fit_viewport_calculator #(
  parameter int MENU_W = 640,
  parameter int MENU_H = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] src_width, [19:10] src_height
  input  logic [1:0]  in_tuser,   // [1:0] out_system
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [9:0] out_width, [19:10] out_height,
                                  // [29:20] left_offset, [39:30] top_offset
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata
);

  localparam int          CTX_W    = $bits(afvc_pkg::ctx_t);
  localparam logic [9:0]  MENU_W_C = MENU_W[9:0];
  localparam logic [9:0]  MENU_H_C = MENU_H[9:0];

  afvc_pkg::mode_t mode_r;
  logic [19:0]     ratio_r;
  logic            filt_r;
  logic            rot_r;

  logic en;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= afvc_pkg::MODE_ASPECT;
      ratio_r <= afvc_pkg::RATIO_RESET;
      filt_r  <= 1'b1;
      rot_r   <= 1'b0;
    end else if (cfg_we) begin
      case (afvc_pkg::reg_idx_t'(cfg_addr))
        afvc_pkg::REG_MODE:   mode_r  <= afvc_pkg::mode_t'(cfg_wdata[1:0]);
        afvc_pkg::REG_RATIO:  ratio_r <= cfg_wdata;
        afvc_pkg::REG_FILT:   filt_r  <= cfg_wdata[0];
        afvc_pkg::REG_ROTATE: rot_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  // Front end: axis swap, screen, menu check, integer-factor divide setup
  afvc_pkg::ctx_t ctx0;
  logic [9:0]     w0, h0, num_a, den_a;
  logic [19:0]    pw, ph;

  always_comb begin
    w0   = in_tdata[9:0];
    h0   = in_tdata[19:10];
    ctx0 = '0;
    ctx0.swap = (in_tuser == afvc_pkg::SYS_LCD) && rot_r;
    ctx0.uw   = ctx0.swap ? h0 : w0;
    ctx0.uh   = ctx0.swap ? w0 : h0;
    if (in_tuser == afvc_pkg::SYS_LCD) begin
      ctx0.sw = afvc_pkg::LCD_W;
      ctx0.sh = afvc_pkg::LCD_H;
    end else begin
      ctx0.sw = afvc_pkg::TV_W;
      ctx0.sh = (in_tuser == afvc_pkg::SYS_PAL) ? afvc_pkg::PAL_H : afvc_pkg::NTSC_H;
    end
    ctx0.menu = rot_r ? (w0 == MENU_H_C && h0 == MENU_W_C)
                      : (w0 == MENU_W_C && h0 == MENU_H_C);
    pw      = 20'(ctx0.sw) * 20'(ctx0.uh);
    ph      = 20'(ctx0.sh) * 20'(ctx0.uw);
    ctx0.kw = pw < ph;
    num_a   = ctx0.kw ? ctx0.sw : ctx0.sh;
    den_a   = ctx0.kw ? ctx0.uw : ctx0.uh;
  end

  logic           a_valid;
  logic [9:0]     a_quo;
  logic [CTX_W-1:0] a_pay;

  afvc_div #(.NUM_W(10), .DEN_W(10), .PAY_W(CTX_W)) u_div_k (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_valid(in_tvalid), .i_num(num_a), .i_den(den_a), .i_pay(ctx0),
    .o_valid(a_valid), .o_quo(a_quo), .o_pay(a_pay)
  );

  // Clamp the integer factor, set up the source-ratio divide
  afvc_pkg::ctx_t ctx1;
  logic           dz;
  logic [27:0]    num_b;
  logic [10:0]    den_b;

  always_comb begin
    ctx1   = afvc_pkg::ctx_t'(a_pay);
    dz     = ctx1.kw ? (ctx1.uw == '0) : (ctx1.uh == '0);
    ctx1.k = (dz || a_quo == '0) ? 10'd1 : a_quo;
    num_b  = {1'b0, ctx1.uw, 17'b0} + 28'(ctx1.uh);
    den_b  = {ctx1.uh, 1'b0};
  end

  logic             b_valid;
  logic [27:0]      b_quo;
  logic [CTX_W-1:0] b_pay;

  afvc_div #(.NUM_W(28), .DEN_W(11), .PAY_W(CTX_W)) u_div_src (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_valid(a_valid), .i_num(num_b), .i_den(den_b), .i_pay(ctx1),
    .o_valid(b_valid), .o_quo(b_quo), .o_pay(b_pay)
  );

  // Pick the fit ratio
  afvc_pkg::ctx_t ctx2, s2_r;
  logic           s2_valid_r;
  logic [19:0]    src_ratio;

  always_comb begin
    ctx2 = afvc_pkg::ctx_t'(b_pay);
    if (ctx2.uh == '0) begin
      src_ratio = '0;
    end else if (|b_quo[27:20]) begin
      src_ratio = afvc_pkg::Q16_MAX;
    end else begin
      src_ratio = b_quo[19:0];
    end
    ctx2.ratio = (mode_r == afvc_pkg::MODE_SQUARE) ? src_ratio : ratio_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= ctx2;
    end
  end

  // Scaled sizes by multiply, set up the fitted-height divide
  afvc_pkg::ctx_t ctx3;
  logic [29:0]    prod;
  logic [27:0]    num_c;
  logic [20:0]    den_c;

  always_comb begin
    ctx3     = s2_r;
    prod     = 30'(s2_r.sh) * 30'(s2_r.ratio) + 30'd32768;
    ctx3.scw = prod[29:16];
    ctx3.iw  = 20'(s2_r.uw) * 20'(s2_r.k);
    ctx3.ih  = 20'(s2_r.uh) * 20'(s2_r.k);
    num_c    = {1'b0, s2_r.sw, 17'b0} + 28'(s2_r.ratio);
    den_c    = {s2_r.ratio, 1'b0};
  end

  logic             c_valid;
  logic [27:0]      c_quo;
  logic [CTX_W-1:0] c_pay;

  afvc_div #(.NUM_W(28), .DEN_W(21), .PAY_W(CTX_W)) u_div_fit (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_valid(s2_valid_r), .i_num(num_c), .i_den(den_c), .i_pay(ctx3),
    .o_valid(c_valid), .o_quo(c_quo), .o_pay(c_pay)
  );

  // Choose output size and which margins apply
  afvc_pkg::ctx_t ctx4, s4_r;
  logic           s4_valid_r;
  logic           ratio_fit;

  always_comb begin
    ctx4 = afvc_pkg::ctx_t'(c_pay);
    ctx4.fw = 28'(ctx4.sw);
    ctx4.fh = 28'(ctx4.sh);
    ctx4.ml = 1'b0;
    ctx4.mt = 1'b0;
    case (mode_r)
      afvc_pkg::MODE_ASPECT, afvc_pkg::MODE_CUSTOM: ratio_fit = 1'b1;
      afvc_pkg::MODE_SQUARE:                        ratio_fit = filt_r;
      default:                                      ratio_fit = 1'b0;
    endcase
    if (!ctx4.menu && mode_r != afvc_pkg::MODE_FULL) begin
      if (ratio_fit) begin
        if (ctx4.scw < 14'(ctx4.sw)) begin
          ctx4.fw = 28'(ctx4.scw);
          ctx4.ml = 1'b1;
        end else begin
          ctx4.fh = (ctx4.ratio == '0) ? '0 : c_quo;
          ctx4.mt = 1'b1;
        end
      end else begin
        ctx4.fw = 28'(ctx4.iw);
        ctx4.fh = 28'(ctx4.ih);
        ctx4.ml = 1'b1;
        ctx4.mt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= ctx4;
    end
  end

  // Margin numerators: half the spare screen times the source size
  afvc_pkg::ctx_t ctx5;
  logic           use_l, use_t;
  logic [9:0]     spare_l, spare_t;
  logic [18:0]    num_d;
  logic [9:0]     den_d;

  always_comb begin
    ctx5    = s4_r;
    use_l   = s4_r.ml && s4_r.fw != '0 && s4_r.fw < 28'(s4_r.sw);
    use_t   = s4_r.mt && s4_r.fh != '0 && s4_r.fh < 28'(s4_r.sh);
    spare_l = s4_r.sw - s4_r.fw[9:0];
    spare_t = s4_r.sh - s4_r.fh[9:0];
    if (use_l) begin
      num_d = 19'(spare_l[9:1]) * 19'(s4_r.uw);
      den_d = s4_r.fw[9:0];
    end else begin
      num_d = '0;
      den_d = 10'd1;
    end
    if (use_t) begin
      ctx5.numt = 19'(spare_t[9:1]) * 19'(s4_r.uh);
      ctx5.dent = s4_r.fh[9:0];
    end else begin
      ctx5.numt = '0;
      ctx5.dent = 10'd1;
    end
  end

  logic             d_valid;
  logic [18:0]      d_quo;
  logic [CTX_W-1:0] d_pay;

  afvc_div #(.NUM_W(19), .DEN_W(10), .PAY_W(CTX_W)) u_div_left (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_valid(s4_valid_r), .i_num(num_d), .i_den(den_d), .i_pay(ctx5),
    .o_valid(d_valid), .o_quo(d_quo), .o_pay(d_pay)
  );

  // Saturate left margin, run the top margin divide
  afvc_pkg::ctx_t ctx6;

  always_comb begin
    ctx6      = afvc_pkg::ctx_t'(d_pay);
    ctx6.left = (|d_quo[18:10]) ? afvc_pkg::FIELD_MAX : d_quo[9:0];
  end

  logic             e_valid;
  logic [18:0]      e_quo;
  logic [CTX_W-1:0] e_pay;

  afvc_div #(.NUM_W(19), .DEN_W(10), .PAY_W(CTX_W)) u_div_top (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_valid(d_valid), .i_num(ctx6.numt), .i_den(ctx6.dent), .i_pay(ctx6),
    .o_valid(e_valid), .o_quo(e_quo), .o_pay(e_pay)
  );

  // Swap back and pack the result word
  afvc_pkg::ctx_t ctx7;
  logic [9:0]     top_sat;
  logic [39:0]    out_nxt;

  always_comb begin
    ctx7    = afvc_pkg::ctx_t'(e_pay);
    top_sat = (|e_quo[18:10]) ? afvc_pkg::FIELD_MAX : e_quo[9:0];
    if (ctx7.swap) begin
      out_nxt = {ctx7.left, top_sat, ctx7.fw[9:0], ctx7.fh[9:0]};
    end else begin
      out_nxt = {top_sat, ctx7.left, ctx7.fh[9:0], ctx7.fw[9:0]};
    end
  end

  logic        out_valid_r;
  logic [39:0] out_data_r;

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `AFVC_ASSERT_IMPL(a_full_is_screen, out_tvalid && mode_r == afvc_pkg::MODE_FULL,
    out_tdata[9:0] == afvc_pkg::LCD_W || out_tdata[9:0] == afvc_pkg::LCD_H ||
    out_tdata[9:0] == afvc_pkg::TV_W, "full-screen width is not a screen width")
  `AFVC_ASSERT_IMPL(a_one_margin,
    out_tvalid && (mode_r == afvc_pkg::MODE_ASPECT || mode_r == afvc_pkg::MODE_CUSTOM),
    out_tdata[29:20] == '0 || out_tdata[39:30] == '0, "ratio fit gave two margins")
  `AFVC_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid, "output valid after reset")

endmodule

// ----- dv/aspect_fit_viewport_calculator_tb.sv -----
`timescale 1ns / 1ps
module aspect_fit_viewport_calculator_tb;

  localparam logic [1:0] SYS_NTSC = 2'd2;
  localparam logic [1:0] SYS_ODD  = 2'd3;
  localparam int DRAIN_CYCLES = 130;

  typedef struct {
    logic [9:0] width;
    logic [9:0] height;
    logic [9:0] left;
    logic [9:0] top;
  } viewport_t;

  // Mirror of the block: register copy, viewport predictor, pending results
  class viewport_scoreboard;
    afvc_pkg::mode_t mode;
    logic [19:0]     ratio;
    logic            filt;
    logic            rot;
    viewport_t       pending_views[$];
    int              errors;

    function new();
      mode   = afvc_pkg::MODE_ASPECT;
      ratio  = afvc_pkg::RATIO_RESET;
      filt   = 1'b1;
      rot    = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(afvc_pkg::reg_idx_t idx, logic [19:0] value);
      case (idx)
        afvc_pkg::REG_MODE:   mode  = afvc_pkg::mode_t'(value[1:0]);
        afvc_pkg::REG_RATIO:  ratio = value;
        afvc_pkg::REG_FILT:   filt  = value[0];
        afvc_pkg::REG_ROTATE: rot   = value[0];
        default: ;
      endcase
    endfunction

    function longint unsigned margin(longint unsigned screen, longint unsigned scaled,
                                     longint unsigned src);
      longint unsigned m;
      if (scaled == 0 || scaled >= screen) return 0;
      m = (screen - scaled) / 2 * src / scaled;
      return (m > 1023) ? 1023 : m;
    endfunction

    // Fit to a width/height ratio on whichever axis is short
    function void fit_ratio(longint unsigned uw, longint unsigned uh, longint unsigned r,
                            inout longint unsigned sw, inout longint unsigned sh,
                            inout longint unsigned left, inout longint unsigned top);
      longint unsigned scw, sch;
      scw = (sh * r + 32768) >> 16;
      if (scw < sw) begin
        left = margin(sw, scw, uw);
        sw   = scw;
      end else begin
        sch = (r == 0) ? 0 : ((sw << 17) + r) / (2 * r);
        top = margin(sh, sch, uh);
        sh  = sch;
      end
    endfunction

    // Whole-number scale factor, never below one
    function void fit_whole(longint unsigned uw, longint unsigned uh,
                            inout longint unsigned sw, inout longint unsigned sh,
                            inout longint unsigned left, inout longint unsigned top);
      longint unsigned k, scw, sch;
      if (sw * uh < sh * uw) k = (uw == 0) ? 1 : sw / uw;
      else                   k = (uh == 0) ? 1 : sh / uh;
      if (k < 1) k = 1;
      scw  = uw * k;
      sch  = uh * k;
      left = margin(sw, scw, uw);
      top  = margin(sh, sch, uh);
      sw   = scw;
      sh   = sch;
    endfunction

    function void note_request(logic [9:0] w, logic [9:0] h, logic [1:0] sys);
      longint unsigned uw, uh, sw, sh, left, top, r, t;
      logic swap, menu;
      viewport_t v;
      swap = (sys == afvc_pkg::SYS_LCD) && rot;
      uw   = swap ? 64'(h) : 64'(w);
      uh   = swap ? 64'(w) : 64'(h);
      left = 0;
      top  = 0;
      if (sys == afvc_pkg::SYS_LCD) begin
        sw = 64'(afvc_pkg::LCD_W);
        sh = 64'(afvc_pkg::LCD_H);
      end else begin
        sw = 64'(afvc_pkg::TV_W);
        sh = (sys == afvc_pkg::SYS_PAL) ? 64'(afvc_pkg::PAL_H) : 64'(afvc_pkg::NTSC_H);
      end
      if (rot) menu = (w == 10'd480) && (h == 10'd640);
      else     menu = (w == 10'd640) && (h == 10'd480);
      if (!menu) begin
        case (mode)
          afvc_pkg::MODE_ASPECT, afvc_pkg::MODE_CUSTOM:
            fit_ratio(uw, uh, 64'(ratio), sw, sh, left, top);
          afvc_pkg::MODE_SQUARE: begin
            if (filt) begin
              r = 0;
              if (uh != 0) begin
                r = ((uw << 17) + uh) / (2 * uh);
                if (r > 64'(afvc_pkg::Q16_MAX)) r = 64'(afvc_pkg::Q16_MAX);
              end
              fit_ratio(uw, uh, r, sw, sh, left, top);
            end else begin
              fit_whole(uw, uh, sw, sh, left, top);
            end
          end
          default: ;
        endcase
      end
      if (swap) begin
        t = sw;   sw = sh;     sh = t;
        t = left; left = top;  top = t;
      end
      v.width  = sw[9:0];
      v.height = sh[9:0];
      v.left   = left[9:0];
      v.top    = top[9:0];
      pending_views.push_back(v);
    endfunction

    function void check_result(logic [39:0] word);
      viewport_t e;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected word %h", $time, word);
        errors++;
        return;
      end
      e = pending_views.pop_front();
      if (word[9:0] !== e.width) begin
        $display("%0t: out_width exp %0d got %0d", $time, e.width, word[9:0]);
        errors++;
      end
      if (word[19:10] !== e.height) begin
        $display("%0t: out_height exp %0d got %0d", $time, e.height, word[19:10]);
        errors++;
      end
      if (word[29:20] !== e.left) begin
        $display("%0t: left_offset exp %0d got %0d", $time, e.left, word[29:20]);
        errors++;
      end
      if (word[39:30] !== e.top) begin
        $display("%0t: top_offset exp %0d got %0d", $time, e.top, word[39:30]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [19:0] cfg_wdata;

  viewport_scoreboard sb;

  aspect_fit_viewport_calculator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall pattern, with stall-free stretches
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic write_cfg(afvc_pkg::reg_idx_t idx, logic [19:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one word and hold it until accepted
  task automatic send_size(logic [9:0] w, logic [9:0] h, logic [1:0] sys);
    int n;
    n = pick_gap();
    repeat (n) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, h, w};
    in_tuser  = sys;
    do @(posedge clk); while (!in_tready);
    sb.note_request(w, h, sys);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random();
    logic [9:0] w, h;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      w = 10'($urandom_range(1, 640));
      h = 10'($urandom_range(1, 640));
    end else if (roll < 88) begin
      w = 10'($urandom_range(0, 1023));
      h = 10'($urandom_range(0, 1023));
    end else if (roll < 94) begin
      w = 10'd640;
      h = 10'd480;
    end else begin
      w = 10'd480;
      h = 10'd640;
    end
    send_size(w, h, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    afvc_pkg::mode_t modes [12];
    logic [19:0]     ratios[12];
    logic            filts [12];
    logic            rots  [12];
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = afvc_pkg::REG_MODE;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: menu sizes, field extremes, every output system at reset settings
    send_size(10'd640, 10'd480, afvc_pkg::SYS_LCD);
    send_size(10'd480, 10'd640, afvc_pkg::SYS_PAL);
    send_size(10'd1, 10'd1, SYS_NTSC);
    send_size(10'd1023, 10'd1023, SYS_ODD);
    send_size(10'd0, 10'd0, afvc_pkg::SYS_LCD);
    send_size(10'd1023, 10'd1, afvc_pkg::SYS_PAL);
    send_size(10'd1, 10'd1023, SYS_NTSC);
    send_size(10'd320, 10'd240, afvc_pkg::SYS_LCD);
    send_size(10'd256, 10'd224, SYS_ODD);
    send_size(10'd0, 10'd512, afvc_pkg::SYS_PAL);
    send_size(10'd682, 10'd341, afvc_pkg::SYS_LCD);
    send_size(10'd341, 10'd682, SYS_NTSC);
    drain();

    // Settings per phase, extremes included
    modes  = '{afvc_pkg::MODE_FULL, afvc_pkg::MODE_SQUARE, afvc_pkg::MODE_SQUARE,
               afvc_pkg::MODE_SQUARE, afvc_pkg::MODE_SQUARE, afvc_pkg::MODE_ASPECT,
               afvc_pkg::MODE_CUSTOM, afvc_pkg::MODE_CUSTOM, afvc_pkg::MODE_CUSTOM,
               afvc_pkg::MODE_ASPECT, afvc_pkg::MODE_FULL, afvc_pkg::MODE_SQUARE};
    ratios = '{20'd87381, 20'd87381, 20'd1, 20'd1, 20'd116508, 20'hFFFFF,
               20'd1, 20'd0, 20'd0, 20'd65536, 20'hFFFFF, 20'd0};
    filts  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    rots   = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    for (int p = 0; p < 12; p++) begin
      if (p == 9) ratios[p] = 20'($urandom_range(1, 20'hFFFFF));
      write_cfg(afvc_pkg::REG_MODE, 20'(modes[p]));
      write_cfg(afvc_pkg::REG_RATIO, ratios[p]);
      write_cfg(afvc_pkg::REG_FILT, 20'(filts[p]));
      write_cfg(afvc_pkg::REG_ROTATE, 20'(rots[p]));
      repeat (70) send_random();
      // Short directed burst on the special sizes for this setting
      send_size(10'd640, 10'd480, 2'($urandom_range(0, 3)));
      send_size(10'd480, 10'd640, afvc_pkg::SYS_LCD);
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/afvc_pkg.sv
rtl/afvc_div_cell.sv
rtl/afvc_div.sv
rtl/aspect_fit_viewport_calculator.sv
dv/aspect_fit_viewport_calculator_tb.sv
